>>> rtl/hpt_pkg.sv
// shared types, constants and helpers for the humidity/pressure/temperature compensation
// no dependencies
`default_nettype none
package hpt_pkg;

   localparam int WordW = 32;
   localparam int AddrW = 6;
   localparam int DataW = 64;
   localparam int HumW  = 17;

   localparam logic [2:0] RegTemp   = 3'd0;
   localparam logic [2:0] RegPressA = 3'd1;
   localparam logic [2:0] RegPressB = 3'd2;
   localparam logic [2:0] RegPressC = 3'd3;
   localparam logic [2:0] RegHumA   = 3'd4;
   localparam logic [2:0] RegHumB   = 3'd5;

   localparam logic [WordW-1:0] HumClampMax = 32'd419430400;

   typedef struct packed {
      logic [WordW-1:0] temp;
      logic [WordW-1:0] hum;
      logic             zero;
      logic             pre_shift;
   } side_type;

   localparam int SideW = $bits(side_type);

   function automatic logic [WordW-1:0] sar(input logic [WordW-1:0] x, input int unsigned n);
      sar = WordW'($signed(x) >>> n);
   endfunction

   function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
      sx16 = {{(WordW-16){w[15]}}, w};
   endfunction

endpackage
`default_nettype wire

>>> rtl/hpt_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage, with sideband
// depends on hpt_pkg only through the parameter values given by the top level
`default_nettype none
module hpt_div #(
   parameter int WIDTH  = 32,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [WIDTH-1:0]  in_num,
   input  wire logic [WIDTH-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [WIDTH-1:0]       out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   logic              v_ff    [WIDTH];
   logic [WIDTH-1:0]  rem_ff  [WIDTH];
   logic [WIDTH-1:0]  num_ff  [WIDTH];
   logic [WIDTH-1:0]  den_ff  [WIDTH];
   logic [SIDE_W-1:0] side_ff [WIDTH];

   for (genvar i = 0; i < WIDTH; i++) begin : g_stage
      logic              v_prev;
      logic [WIDTH-1:0]  rem_prev, num_prev, den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [WIDTH:0]    trial, diff;
      logic [WIDTH-1:0]  rem_in, num_in;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign num_prev  = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign num_prev  = num_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         trial = {rem_prev, num_prev[WIDTH-1]};
         diff  = trial - {1'b0, den_prev};
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            num_in = {num_prev[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            num_in = {num_prev[WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_prev;
         end
         if (en) begin
            rem_ff[i]  <= rem_in;
            num_ff[i]  <= num_in;
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[WIDTH-1];
   assign out_quot  = num_ff[WIDTH-1];
   assign out_side  = side_ff[WIDTH-1];

endmodule
`default_nettype wire

>>> rtl/humidity_pressure_temp_compensation.sv
// one transaction per cycle unless a stalled response holds the pipeline
// pipeline: 11 arithmetic stages, a 32-stage divider pipeline and 5 more stages
// the response register holds while rsp_valid and rsp_stall are both high and the whole pipeline holds with it
// synchronous active-high reset clears all valid bits and the calibration registers to 0
// depends on hpt_pkg and hpt_div
`default_nettype none
module humidity_pressure_temp_compensation (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [19:0]              req_raw_temperature,
   input  wire logic [19:0]              req_raw_pressure,
   input  wire logic [15:0]              req_raw_humidity,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [31:0]            rsp_temperature_centideg,
   output logic [31:0]                   rsp_pressure_pascal,
   output logic [hpt_pkg::HumW-1:0]      rsp_humidity_q10,
   output logic                          rsp_pressure_divisor_zero,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [hpt_pkg::AddrW-1:0] paddr,
   input  wire logic [hpt_pkg::DataW-1:0] pwdata,
   output logic [hpt_pkg::DataW-1:0]     prdata,
   output logic                          pready
);

   typedef logic [hpt_pkg::WordW-1:0] word_type;

   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff, press_b_ff;
   logic [15:0] press_c_ff;
   logic [39:0] hum_a_ff;
   logic [31:0] hum_b_ff;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
         hum_a_ff      <= '0;
         hum_b_ff      <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            hpt_pkg::RegTemp:   temp_calib_ff <= pwdata[47:0];
            hpt_pkg::RegPressA: press_a_ff    <= pwdata;
            hpt_pkg::RegPressB: press_b_ff    <= pwdata;
            hpt_pkg::RegPressC: press_c_ff    <= pwdata[15:0];
            hpt_pkg::RegHumA:   hum_a_ff      <= pwdata[39:0];
            hpt_pkg::RegHumB:   hum_b_ff      <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         hpt_pkg::RegTemp:   prdata = {16'd0, temp_calib_ff};
         hpt_pkg::RegPressA: prdata = press_a_ff;
         hpt_pkg::RegPressB: prdata = press_b_ff;
         hpt_pkg::RegPressC: prdata = {48'd0, press_c_ff};
         hpt_pkg::RegHumA:   prdata = {24'd0, hum_a_ff};
         hpt_pkg::RegHumB:   prdata = {32'd0, hum_b_ff};
         default:            prdata = '0;
      endcase
   end

   word_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, temp_calib_ff[15:0]};
   assign t2 = hpt_pkg::sx16(temp_calib_ff[31:16]);
   assign t3 = hpt_pkg::sx16(temp_calib_ff[47:32]);
   assign p1 = {16'd0, press_a_ff[15:0]};
   assign p2 = hpt_pkg::sx16(press_a_ff[31:16]);
   assign p3 = hpt_pkg::sx16(press_a_ff[47:32]);
   assign p4 = hpt_pkg::sx16(press_a_ff[63:48]);
   assign p5 = hpt_pkg::sx16(press_b_ff[15:0]);
   assign p6 = hpt_pkg::sx16(press_b_ff[31:16]);
   assign p7 = hpt_pkg::sx16(press_b_ff[47:32]);
   assign p8 = hpt_pkg::sx16(press_b_ff[63:48]);
   assign p9 = hpt_pkg::sx16(press_c_ff);
   assign h1 = {24'd0, hum_a_ff[7:0]};
   assign h2 = hpt_pkg::sx16(hum_a_ff[23:8]);
   assign h3 = {24'd0, hum_a_ff[31:24]};
   assign h6 = {{24{hum_a_ff[39]}}, hum_a_ff[39:32]};
   assign h4 = hpt_pkg::sx16(hum_b_ff[15:0]);
   assign h5 = hpt_pkg::sx16(hum_b_ff[31:16]);

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff, s8_v_ff, s9_v_ff;
   logic s10_v_ff, s11_v_ff, d1_v_ff, d2_v_ff, d3_v_ff, d4_v_ff, rsp_v_ff;
   logic div_v;

   word_type a1_ff, b1_ff;
   logic [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff, ap7_ff, ap8_ff;
   logic [15:0] ah1_ff, ah2_ff, ah3_ff, ah4_ff, ah5_ff, ah6_ff;
   word_type ma2_ff, bb2_ff, v13_ff, c3_ff, tf4_ff;
   word_type t5_ff, t6_ff, t7_ff, t8_ff, t9_ff, t10_ff, t11_ff;
   word_type pv5_ff, q5_ff, hx5_ff;
   word_type qq6_ff, m56_ff, m26_ff, hx66_ff, hx36_ff, h5x6_ff;
   word_type v2a7_ff, m37_ff, m57_ff, m27_ff, inner7_ff, left7_ff;
   word_type v28_ff, v18_ff, inner8_ff, left8_ff;
   word_type d9_ff, rpre9_ff, pn9_ff, left9_ff;
   word_type div10_ff, right10_ff, pm10_ff, left10_ff;
   word_type hum11_ff, num11_ff, den11_ff;
   logic     zero11_ff, small11_ff;

   word_type pv_c, tf5_c, left_c;
   assign pv_c   = hpt_pkg::sar(tf4_ff, 1) - word_type'(64000);
   assign tf5_c  = tf4_ff + (tf4_ff << 2) + word_type'(128);
   assign left_c = ({16'd0, ah6_ff} << 14) - (h4 << 20) - h5x6_ff + word_type'(16384);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
         s11_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= s7_v_ff;
         s9_v_ff  <= s8_v_ff;
         s10_v_ff <= s9_v_ff;
         s11_v_ff <= s10_v_ff;
      end
      if (adv) begin
         // fine temperature
         a1_ff  <= word_type'(req_raw_temperature >> 3) - (t1 << 1);
         b1_ff  <= word_type'(req_raw_temperature >> 4) - t1;
         ap1_ff <= req_raw_pressure;
         ah1_ff <= req_raw_humidity;

         ma2_ff <= a1_ff * t2;
         bb2_ff <= b1_ff * b1_ff;
         ap2_ff <= ap1_ff;
         ah2_ff <= ah1_ff;

         v13_ff <= hpt_pkg::sar(ma2_ff, 11);
         c3_ff  <= hpt_pkg::sar(bb2_ff, 12) * t3;
         ap3_ff <= ap2_ff;
         ah3_ff <= ah2_ff;

         tf4_ff <= v13_ff + hpt_pkg::sar(c3_ff, 14);
         ap4_ff <= ap3_ff;
         ah4_ff <= ah3_ff;

         t5_ff  <= hpt_pkg::sar(tf5_c, 8);
         pv5_ff <= pv_c;
         q5_ff  <= hpt_pkg::sar(pv_c, 2);
         hx5_ff <= tf4_ff - word_type'(76800);
         ap5_ff <= ap4_ff;
         ah5_ff <= ah4_ff;

         // products on the fine temperature
         qq6_ff  <= q5_ff * q5_ff;
         m56_ff  <= pv5_ff * p5;
         m26_ff  <= p2 * pv5_ff;
         hx66_ff <= hx5_ff * h6;
         hx36_ff <= hx5_ff * h3;
         h5x6_ff <= h5 * hx5_ff;
         t6_ff   <= t5_ff;
         ap6_ff  <= ap5_ff;
         ah6_ff  <= ah5_ff;

         v2a7_ff   <= hpt_pkg::sar(qq6_ff, 11) * p6;
         m37_ff    <= p3 * hpt_pkg::sar(qq6_ff, 13);
         m57_ff    <= m56_ff;
         m27_ff    <= m26_ff;
         inner7_ff <= hpt_pkg::sar(hx66_ff, 10)
                      * (hpt_pkg::sar(hx36_ff, 11) + word_type'(32768));
         left7_ff  <= hpt_pkg::sar(left_c, 15);
         t7_ff     <= t6_ff;
         ap7_ff    <= ap6_ff;

         v28_ff    <= hpt_pkg::sar(v2a7_ff + (m57_ff << 1), 2) + (p4 << 16);
         v18_ff    <= hpt_pkg::sar(hpt_pkg::sar(m37_ff, 3) + hpt_pkg::sar(m27_ff, 1), 18);
         inner8_ff <= hpt_pkg::sar(inner7_ff, 10) + word_type'(2097152);
         left8_ff  <= left7_ff;
         t8_ff     <= t7_ff;
         ap8_ff    <= ap7_ff;

         d9_ff     <= (word_type'(32768) + v18_ff) * p1;
         rpre9_ff  <= inner8_ff * h2 + word_type'(8192);
         pn9_ff    <= (word_type'(1048576) - {12'd0, ap8_ff}) - hpt_pkg::sar(v28_ff, 12);
         left9_ff  <= left8_ff;
         t9_ff     <= t8_ff;

         div10_ff   <= hpt_pkg::sar(d9_ff, 15);
         right10_ff <= hpt_pkg::sar(rpre9_ff, 14);
         pm10_ff    <= pn9_ff * word_type'(3125);
         left10_ff  <= left9_ff;
         t10_ff     <= t9_ff;

         // divider operands
         hum11_ff   <= left10_ff * right10_ff;
         zero11_ff  <= (div10_ff == '0);
         small11_ff <= !pm10_ff[31];
         num11_ff   <= pm10_ff[31] ? pm10_ff : (pm10_ff << 1);
         den11_ff   <= div10_ff;
         t11_ff     <= t10_ff;
      end
   end

   hpt_pkg::side_type side_in, side_out;
   word_type          quot;

   assign side_in = '{temp: t11_ff, hum: hum11_ff, zero: zero11_ff, pre_shift: small11_ff};

   hpt_div #(
      .WIDTH  (hpt_pkg::WordW),
      .SIDE_W (hpt_pkg::SideW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s11_v_ff),
      .in_num    (num11_ff),
      .in_den    (den11_ff),
      .in_side   (side_in),
      .out_valid (div_v),
      .out_quot  (quot),
      .out_side  (side_out)
   );

   word_type p_d1_ff, s_d1_ff, hum_d1_ff, t_d1_ff;
   word_type p_d2_ff, pp_d2_ff, w2_d2_ff, ss_d2_ff, hum_d2_ff, t_d2_ff;
   word_type p_d3_ff, w1_d3_ff, w2_d3_ff, hm_d3_ff, hum_d3_ff, t_d3_ff;
   word_type p_d4_ff, x_d4_ff, t_d4_ff;
   logic     z_d1_ff, z_d2_ff, z_d3_ff, z_d4_ff;
   word_type padj_c, x_c;

   assign padj_c = hpt_pkg::sar(hpt_pkg::sar(w1_d3_ff, 12) + hpt_pkg::sar(w2_d3_ff, 13) + p7, 4);
   assign x_c    = hum_d3_ff - hpt_pkg::sar(hm_d3_ff, 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff  <= 1'b0;
         d2_v_ff  <= 1'b0;
         d3_v_ff  <= 1'b0;
         d4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         d1_v_ff  <= div_v;
         d2_v_ff  <= d1_v_ff;
         d3_v_ff  <= d2_v_ff;
         d4_v_ff  <= d3_v_ff;
         rsp_v_ff <= d4_v_ff;
      end
      if (adv) begin
         p_d1_ff   <= side_out.pre_shift ? quot : (quot << 1);
         s_d1_ff   <= hpt_pkg::sar(side_out.hum, 15);
         hum_d1_ff <= side_out.hum;
         t_d1_ff   <= side_out.temp;
         z_d1_ff   <= side_out.zero;

         pp_d2_ff  <= (p_d1_ff >> 3) * (p_d1_ff >> 3);
         w2_d2_ff  <= (p_d1_ff >> 2) * p8;
         ss_d2_ff  <= s_d1_ff * s_d1_ff;
         p_d2_ff   <= p_d1_ff;
         hum_d2_ff <= hum_d1_ff;
         t_d2_ff   <= t_d1_ff;
         z_d2_ff   <= z_d1_ff;

         w1_d3_ff  <= p9 * (pp_d2_ff >> 13);
         hm_d3_ff  <= hpt_pkg::sar(ss_d2_ff, 7) * h1;
         w2_d3_ff  <= w2_d2_ff;
         p_d3_ff   <= p_d2_ff;
         hum_d3_ff <= hum_d2_ff;
         t_d3_ff   <= t_d2_ff;
         z_d3_ff   <= z_d2_ff;

         p_d4_ff <= z_d3_ff ? '0 : (p_d3_ff + padj_c);
         x_d4_ff <= x_c;
         t_d4_ff <= t_d3_ff;
         z_d4_ff <= z_d3_ff;

         // humidity clamp and output register
         rsp_temperature_centideg  <= $signed(t_d4_ff);
         rsp_pressure_pascal       <= p_d4_ff;
         rsp_pressure_divisor_zero <= z_d4_ff;
         if (x_d4_ff[31]) begin
            rsp_humidity_q10 <= '0;
         end else if (x_d4_ff > hpt_pkg::HumClampMax) begin
            rsp_humidity_q10 <= hpt_pkg::HumW'(hpt_pkg::HumClampMax >> 12);
         end else begin
            rsp_humidity_q10 <= x_d4_ff[hpt_pkg::HumW+11:12];
         end
      end
   end

   assign rsp_valid = rsp_v_ff;

endmodule
`default_nettype wire

>>> dv/tb_humidity_pressure_temp_compensation.sv
// testbench for humidity_pressure_temp_compensation: random and directed raw samples
// under several calibration sets, checked in order against an internal scoreboard
// depends on hpt_pkg and the compensation block
`default_nettype none
module tb_humidity_pressure_temp_compensation;

   localparam logic [2:0] RegUnused = 3'd6;
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned Drain = 60;

   typedef struct {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] hum;
      logic        zero;
   } sample_out_type;

   class compensation_scoreboard;
      logic [63:0] calib [6];
      sample_out_type pending [$];
      int errors;

      function new();
         foreach (calib[i]) calib[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            hpt_pkg::RegTemp:   calib[0] = val & 64'hFFFF_FFFF_FFFF;
            hpt_pkg::RegPressA: calib[1] = val;
            hpt_pkg::RegPressB: calib[2] = val;
            hpt_pkg::RegPressC: calib[3] = val & 64'hFFFF;
            hpt_pkg::RegHumA:   calib[4] = val & 64'hFF_FFFF_FFFF;
            hpt_pkg::RegHumB:   calib[5] = val & 64'hFFFF_FFFF;
            default: ;
         endcase
      endfunction

      function logic [31:0] asr(logic [31:0] v, int n);
         return $signed(v) >>> n;
      endfunction

      function logic [31:0] s16(logic [63:0] w, int pos);
         logic [15:0] f;
         f = 16'(w >> pos);
         return {{16{f[15]}}, f};
      endfunction

      function logic [31:0] u16(logic [63:0] w, int pos);
         logic [15:0] f;
         f = 16'(w >> pos);
         return {16'h0, f};
      endfunction

      function void note_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
         logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] h1, h2, h3, h4, h5, h6;
         logic [31:0] a, b, v1, v2, q, qq, tf, p, x, lft, inner, rgt, s, w1, w2, at, ap, ah;
         logic [7:0] b8;
         sample_out_type r;
         at = {12'h0, rt};
         ap = {12'h0, rp};
         ah = {16'h0, rh};
         t1 = u16(calib[0], 0); t2 = s16(calib[0], 16); t3 = s16(calib[0], 32);
         p1 = u16(calib[1], 0); p2 = s16(calib[1], 16);
         p3 = s16(calib[1], 32); p4 = s16(calib[1], 48);
         p5 = s16(calib[2], 0); p6 = s16(calib[2], 16);
         p7 = s16(calib[2], 32); p8 = s16(calib[2], 48);
         p9 = s16(calib[3], 0);
         h1 = {24'h0, calib[4][7:0]};
         h2 = s16(calib[4], 8);
         h3 = {24'h0, calib[4][31:24]};
         b8 = calib[4][39:32];
         h6 = {{24{b8[7]}}, b8};
         h4 = s16(calib[5], 0); h5 = s16(calib[5], 16);

         a = (at >> 3) - (t1 << 1);
         v1 = asr(a * t2, 11);
         b = (at >> 4) - t1;
         v2 = asr(asr(b * b, 12) * t3, 14);
         tf = v1 + v2;
         r.temp = asr(tf * 32'd5 + 32'd128, 8);

         v1 = asr(tf, 1) - 32'd64000;
         q = asr(v1, 2);
         qq = q * q;
         v2 = asr(qq, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = asr(v2, 2) + (p4 << 16);
         v1 = asr(asr(p3 * asr(qq, 13), 3) + asr(p2 * v1, 1), 18);
         v1 = asr((32'd32768 + v1) * p1, 15);
         r.zero = (v1 == 0);
         if (r.zero) begin
            p = 0;
         end else begin
            p = ((32'd1048576 - ap) - asr(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            w1 = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            w2 = asr((p >> 2) * p8, 13);
            p = p + asr(w1 + w2 + p7, 4);
         end
         r.press = p;

         x = tf - 32'd76800;
         lft = asr(((ah << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
         inner = asr(x * h6, 10) * (asr(x * h3, 11) + 32'd32768);
         inner = asr(inner, 10) + 32'd2097152;
         rgt = asr(inner * h2 + 32'd8192, 14);
         x = lft * rgt;
         s = asr(x, 15);
         x = x - asr(asr(s * s, 7) * h1, 4);
         if (x[31]) x = 0;
         if (x > hpt_pkg::HumClampMax) x = hpt_pkg::HumClampMax;
         r.hum = x[28:12];
         pending.push_back(r);
      endfunction

      function void check_sample(sample_out_type got);
         sample_out_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected transaction temp %0d press %0d", $time,
                     $signed(got.temp), got.press);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.temp !== e.temp) begin
            $display("%0t temperature expected %0d got %0d", $time,
                     $signed(e.temp), $signed(got.temp));
            errors++;
         end
         if (got.press !== e.press) begin
            $display("%0t pressure expected %0d got %0d", $time, e.press, got.press);
            errors++;
         end
         if (got.hum !== e.hum) begin
            $display("%0t humidity expected %0d got %0d", $time, e.hum, got.hum);
            errors++;
         end
         if (got.zero !== e.zero) begin
            $display("%0t divisor zero flag expected %0d got %0d", $time, e.zero, got.zero);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic [19:0] req_raw_temperature = 0, req_raw_pressure = 0;
   logic [15:0] req_raw_humidity = 0;
   logic rsp_valid, rsp_stall = 1;
   logic signed [31:0] rsp_temperature_centideg;
   logic [31:0] rsp_pressure_pascal;
   logic [hpt_pkg::HumW-1:0] rsp_humidity_q10;
   logic rsp_pressure_divisor_zero;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [hpt_pkg::AddrW-1:0] paddr = 0;
   logic [hpt_pkg::DataW-1:0] pwdata = 0;
   logic [hpt_pkg::DataW-1:0] prdata;
   logic pready;

   compensation_scoreboard sb = new();
   int unsigned sent = 0;
   int unsigned cycles = 0;
   int unsigned holdoff = 0;
   bit holdoff_done = 0;
   bit quiet;

   humidity_pressure_temp_compensation uut (.*);

   always #2 clock = ~clock;

   assign quiet = (sent >= 900 && sent < 1100);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff != 0) begin
         rsp_stall <= 1'b1;
         holdoff <= holdoff - 1;
      end else if (!holdoff_done && sent == 500) begin
         holdoff_done <= 1'b1;
         holdoff <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
      end
   end

   always @(posedge clock) begin
      sample_out_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.temp = rsp_temperature_centideg;
         got.press = rsp_pressure_pascal;
         got.hum = rsp_humidity_q10;
         got.zero = rsp_pressure_divisor_zero;
         sb.check_sample(got);
      end
   end

   // called and returns at a falling edge
   task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure <= rp;
      req_raw_humidity <= rh;
      do @(posedge clock); while (req_stall);
      sb.note_sample(rt, rp, rh);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, val);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] pack4(int a, int b, int c, int d);
      return {d[15:0], c[15:0], b[15:0], a[15:0]};
   endfunction

   task automatic load_calib(int kind);
      logic [63:0] v [6];
      case (kind)
         0, 1: begin
            v[0] = pack4(27504, 26435, -1000, 0);
            v[1] = pack4(36477, -10685, 3024, 2855);
            v[2] = pack4(140, -7, 15500, -14600);
            v[3] = pack4(6000, 0, 0, 0);
            v[4] = 64'({8'd30, 8'd0, 16'd362, 8'd75});
            v[5] = pack4(313, 50, 0, 0);
            if (kind == 1)
               foreach (v[i]) v[i] = v[i] ^ {$urandom, $urandom} & 64'h0707_0707_0707_0707;
         end
         2: foreach (v[i]) v[i] = {$urandom, $urandom};
         3: foreach (v[i]) v[i] = '1;
         4: foreach (v[i]) v[i] = 64'h7FFF_7FFF_7FFF_7FFF;
         5: foreach (v[i]) v[i] = 64'h8000_8000_8000_8000;
         default: foreach (v[i]) v[i] = '0;
      endcase
      write_reg(hpt_pkg::RegTemp, v[0]);
      write_reg(hpt_pkg::RegPressA, v[1]);
      write_reg(hpt_pkg::RegPressB, v[2]);
      write_reg(hpt_pkg::RegPressC, v[3]);
      write_reg(hpt_pkg::RegHumA, v[4]);
      write_reg(hpt_pkg::RegHumB, v[5]);
   endtask

   initial begin
      int kinds [8] = '{0, 1, 2, 3, 2, 4, 5, 1};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero calibration gives a zero pressure divisor
      send_sample(0, 0, 0);
      send_sample('1, '1, '1);
      send_sample(20'h80000, 20'h7FFFF, 16'h8000);
      drain_pipe();

      load_calib(0);
      write_reg(RegUnused, '1);
      write_reg(hpt_pkg::RegPressC, 64'hABCD_1234_5678_1770);
      send_sample(0, 0, 0);
      send_sample('1, '1, '1);
      send_sample(519888, 415148, 30000);
      send_sample(519888, 415148, 0);
      send_sample(519888, 415148, '1);
      send_sample(400000, 0, 20000);
      send_sample(600000, '1, 40000);
      send_sample(0, 500000, '1);
      send_sample('1, 0, 0);
      send_sample(20'h55555, 20'hAAAAA, 16'h5555);
      send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
      drain_pipe();

      foreach (kinds[k]) begin
         load_calib(kinds[k]);
         repeat (200) begin
            if ($urandom_range(1))
               send_sample(20'($urandom_range(350000, 650000)),
                           20'($urandom_range(250000, 550000)),
                           16'($urandom_range(15000, 50000)));
            else
               send_sample(20'($urandom), 20'($urandom), 16'($urandom));
         end
         drain_pipe();
      end

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
